// ===== design/rpnalu_pkg.sv =====
// Shared types and constants for the RPN stack calculator.
package rpnalu_pkg;

	localparam int STACK_DEPTH_DEF = 4;
	localparam int WORD_WIDTH_DEF  = 32;
	localparam int OUT_LEVELS      = 4;

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0,
		OP_ADD  = 3'd1,
		OP_SUB  = 3'd2,
		OP_MUL  = 3'd3,
		OP_DIV  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DIV0  = 2'd1,
		ST_BADOP = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_ITER = 2'd2
	} fsm_t;

	// Per-cycle move command for every stack cell.
	typedef struct packed {
		logic up;    // take the level below (push)
		logic down;  // take the level above (binary op)
	} cell_ctl_t;

endpackage

// ===== design/rpnalu_cell.sv =====
// One stack level: holds a word and moves it up or down the chain.
module rpnalu_cell #(
	parameter int WORD_WIDTH = rpnalu_pkg::WORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rpnalu_pkg::cell_ctl_t  ctl,
	input  logic [WORD_WIDTH-1:0]  up_d,
	input  logic [WORD_WIDTH-1:0]  down_d,
	output logic [WORD_WIDTH-1:0]  q,
	output logic [WORD_WIDTH-1:0]  d
);

	logic [WORD_WIDTH-1:0] level_q;

	always_comb begin
		if (ctl.up) begin
			d = up_d;
		end else if (ctl.down) begin
			d = down_d;
		end else begin
			d = level_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else begin
			level_q <= d;
		end
	end

	assign q = level_q;

endmodule

// ===== design/rpnalu_seq.sv =====
// Bit-serial multiply (shift-add) and signed divide (restoring), one bit per cycle.
module rpnalu_seq #(
	parameter int WORD_WIDTH = rpnalu_pkg::WORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   is_div,
	input  logic [WORD_WIDTH-1:0]  opnd_a,  // Y
	input  logic [WORD_WIDTH-1:0]  opnd_b,  // X
	output logic                   busy,
	output logic [WORD_WIDTH-1:0]  result
);

	localparam int CW = $clog2(WORD_WIDTH);

	logic                  busy_q;
	logic                  div_q;
	logic                  neg_q;
	logic [CW-1:0]         cnt_q;
	logic [WORD_WIDTH-1:0] acc_q;
	logic [WORD_WIDTH-1:0] opa_q;
	logic [WORD_WIDTH-1:0] opb_q;

	logic [WORD_WIDTH-1:0] mag_a;
	logic [WORD_WIDTH-1:0] mag_b;
	logic [WORD_WIDTH:0]   rem_sh;
	logic [WORD_WIDTH:0]   rem_sub;
	logic                  fits;

	assign mag_a   = opnd_a[WORD_WIDTH-1] ? (~opnd_a + 1'b1) : opnd_a;
	assign mag_b   = opnd_b[WORD_WIDTH-1] ? (~opnd_b + 1'b1) : opnd_b;
	assign rem_sh  = {acc_q, opa_q[WORD_WIDTH-1]};
	assign rem_sub = rem_sh - {1'b0, opb_q};
	assign fits    = rem_sh >= {1'b0, opb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(WORD_WIDTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= is_div;
			neg_q <= opnd_a[WORD_WIDTH-1] ^ opnd_b[WORD_WIDTH-1];
			acc_q <= '0;
			opa_q <= is_div ? mag_a : opnd_a;
			opb_q <= is_div ? mag_b : opnd_b;
		end else if (busy_q) begin
			if (div_q) begin
				if (fits) begin
					acc_q <= rem_sub[WORD_WIDTH-1:0];
					opa_q <= {opa_q[WORD_WIDTH-2:0], 1'b1};
				end else begin
					acc_q <= rem_sh[WORD_WIDTH-1:0];
					opa_q <= {opa_q[WORD_WIDTH-2:0], 1'b0};
				end
			end else begin
				if (opb_q[0]) begin
					acc_q <= acc_q + opa_q;
				end
				opa_q <= {opa_q[WORD_WIDTH-2:0], 1'b0};
				opb_q <= {1'b0, opb_q[WORD_WIDTH-1:1]};
			end
		end
	end

	assign busy   = busy_q;
	assign result = !div_q ? acc_q : (neg_q ? (~opa_q + 1'b1) : opa_q);

endmodule

// ===== design/rpn_stack_alu_top.sv =====
// Top level of the RPN four-level stack calculator.
// Push, add, subtract, divide by zero and error requests finish in the EXEC state and
// raise out_valid; multiply and divide go on to the ITER state, where the serial unit
// retires one operand bit per cycle. One request is in work at a time: a new request is
// taken only after the last has finished and the FSM is back in IDLE, and a result stall
// delays that finish. Reset (arst_n low, async) clears every level, the FSM and out_valid.
module rpn_stack_alu_top #(
	parameter int STACK_DEPTH = rpnalu_pkg::STACK_DEPTH_DEF,
	parameter int WORD_WIDTH  = rpnalu_pkg::WORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    opcode,
	input  logic signed [WORD_WIDTH-1:0]  value,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [WORD_WIDTH-1:0]  level_x,
	output logic signed [WORD_WIDTH-1:0]  level_y,
	output logic signed [WORD_WIDTH-1:0]  level_z,
	output logic signed [WORD_WIDTH-1:0]  level_t,
	output logic [1:0]                    status
);

	// Control state and the request held while it is in work.
	rpnalu_pkg::fsm_t      state_q, state_d;
	logic [2:0]            op_q;
	logic [WORD_WIDTH-1:0] val_q;

	// Output register; a finished request waits here until taken.
	logic                  out_valid_q;
	logic [WORD_WIDTH-1:0] lvl_out_q [rpnalu_pkg::OUT_LEVELS];
	logic [1:0]            status_q;

	// Stack chain: cell 0 is X, cell 1 is Y, and so on upward.
	logic [WORD_WIDTH-1:0] lvl_q [STACK_DEPTH];
	logic [WORD_WIDTH-1:0] lvl_d [STACK_DEPTH];
	logic [WORD_WIDTH-1:0] lvl_view [rpnalu_pkg::OUT_LEVELS];
	rpnalu_pkg::cell_ctl_t ctl;

	// Arithmetic
	logic                  seq_start;
	logic                  seq_busy;
	logic [WORD_WIDTH-1:0] seq_result;
	logic [WORD_WIDTH-1:0] alu_result;
	logic                  slot_free;
	logic                  finish;
	logic [1:0]            status_d;
	logic                  is_push, is_add, is_sub, is_mul, is_div, x_zero;

	assign is_push = op_q == rpnalu_pkg::OP_PUSH;
	assign is_add  = op_q == rpnalu_pkg::OP_ADD;
	assign is_sub  = op_q == rpnalu_pkg::OP_SUB;
	assign is_mul  = op_q == rpnalu_pkg::OP_MUL;
	assign is_div  = op_q == rpnalu_pkg::OP_DIV;
	assign x_zero  = lvl_q[0] == '0;

	// Output slot is free if empty or being drained this cycle.
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		case (op_q)
			rpnalu_pkg::OP_ADD: alu_result = lvl_q[1] + lvl_q[0];
			rpnalu_pkg::OP_SUB: alu_result = lvl_q[1] - lvl_q[0];
			default:            alu_result = seq_result;
		endcase
	end

	// Next state, serial unit start, stack moves and status.
	always_comb begin
		state_d   = state_q;
		seq_start = 1'b0;
		finish    = 1'b0;
		case (state_q)
			rpnalu_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = rpnalu_pkg::S_EXEC;
				end
			end
			rpnalu_pkg::S_EXEC: begin
				if (is_mul || (is_div && !x_zero)) begin
					seq_start = 1'b1;
					state_d   = rpnalu_pkg::S_ITER;
				end else if (slot_free) begin
					finish  = 1'b1;
					state_d = rpnalu_pkg::S_IDLE;
				end
			end
			rpnalu_pkg::S_ITER: begin
				if (!seq_busy && slot_free) begin
					finish  = 1'b1;
					state_d = rpnalu_pkg::S_IDLE;
				end
			end
			default: state_d = rpnalu_pkg::S_IDLE;
		endcase

		if (is_div && x_zero) begin
			status_d = rpnalu_pkg::ST_DIV0;
		end else if (is_push || is_add || is_sub || is_mul || is_div) begin
			status_d = rpnalu_pkg::ST_OK;
		end else begin
			status_d = rpnalu_pkg::ST_BADOP;
		end

		ctl.up   = finish && is_push;
		ctl.down = finish && !is_push && status_d == rpnalu_pkg::ST_OK;
	end

	assign in_stall = state_q != rpnalu_pkg::S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rpnalu_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request capture; payload needs no reset.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_q  <= opcode;
			val_q <= value;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			for (int i = 0; i < rpnalu_pkg::OUT_LEVELS; i++) begin
				lvl_out_q[i] <= lvl_view[i];
			end
			status_q <= status_d;
		end
	end

	// Chain of stack cells. Push moves every level up and X takes the request value;
	// a binary op without error moves levels down, X takes the result and the top takes zero.
	for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
		logic [WORD_WIDTH-1:0] up_in, down_in;
		if (g == 0) begin : g_bottom
			assign up_in   = val_q;
			assign down_in = alu_result;
		end else if (g == STACK_DEPTH - 1) begin : g_top
			assign up_in   = lvl_q[g-1];
			assign down_in = '0;
		end else begin : g_mid
			assign up_in   = lvl_q[g-1];
			assign down_in = lvl_q[g+1];
		end
		rpnalu_cell #(
			.WORD_WIDTH(WORD_WIDTH)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.up_d   (up_in),
			.down_d (down_in),
			.q      (lvl_q[g]),
			.d      (lvl_d[g])
		);
	end

	// Levels beyond the stack depth read as zero.
	for (genvar g = 0; g < rpnalu_pkg::OUT_LEVELS; g++) begin : g_view
		if (g < STACK_DEPTH) begin : g_have
			assign lvl_view[g] = lvl_d[g];
		end else begin : g_none
			assign lvl_view[g] = '0;
		end
	end

	rpnalu_seq #(
		.WORD_WIDTH(WORD_WIDTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seq_start),
		.is_div (is_div),
		.opnd_a (lvl_q[1]),
		.opnd_b (lvl_q[0]),
		.busy   (seq_busy),
		.result (seq_result)
	);

	assign out_valid = out_valid_q;
	assign level_x   = lvl_out_q[0];
	assign level_y   = lvl_out_q[1];
	assign level_z   = lvl_out_q[2];
	assign level_t   = lvl_out_q[3];
	assign status    = status_q;

endmodule
